// ===== sv/cenc_pkg.sv =====
`default_nettype none

package cenc_pkg;

    localparam int MNEM_W = 24;
    localparam int SYN_W  = 4;
    localparam int VAL_W  = 16;
    localparam int OP_W   = 8;
    localparam int SIZE_W = 2;
    localparam int STAT_W = 3;
    localparam int MODE_W = 12;

    localparam logic [MODE_W-1:0] M_IMM  = 12'h001;
    localparam logic [MODE_W-1:0] M_ABS  = 12'h002;
    localparam logic [MODE_W-1:0] M_ZP   = 12'h004;
    localparam logic [MODE_W-1:0] M_ABSX = 12'h008;
    localparam logic [MODE_W-1:0] M_ZPX  = 12'h010;
    localparam logic [MODE_W-1:0] M_ABSY = 12'h020;
    localparam logic [MODE_W-1:0] M_ZPY  = 12'h040;
    localparam logic [MODE_W-1:0] M_INDX = 12'h080;
    localparam logic [MODE_W-1:0] M_INDY = 12'h100;
    localparam logic [MODE_W-1:0] M_ACC  = 12'h200;
    localparam logic [MODE_W-1:0] M_IND  = 12'h400;
    localparam logic [MODE_W-1:0] M_BR   = 12'h800;
    localparam logic [MODE_W-1:0] M_NONE = 12'h000;

    localparam logic [MODE_W-1:0] M_GEN = M_IMM | M_ABS | M_ZP | M_ABSX | M_ZPX | M_ABSY
                                        | M_INDX | M_INDY | M_IND;
    localparam logic [MODE_W-1:0] M_RMW = M_ABS | M_ZP | M_ABSX | M_ZPX;

    localparam logic [SYN_W-1:0] SYN_NONE  = 4'd0;
    localparam logic [SYN_W-1:0] SYN_ACC   = 4'd1;
    localparam logic [SYN_W-1:0] SYN_IMM   = 4'd2;
    localparam logic [SYN_W-1:0] SYN_IND   = 4'd3;
    localparam logic [SYN_W-1:0] SYN_INDX  = 4'd4;
    localparam logic [SYN_W-1:0] SYN_INDY  = 4'd5;
    localparam logic [SYN_W-1:0] SYN_DIR   = 4'd6;
    localparam logic [SYN_W-1:0] SYN_DIRX  = 4'd7;
    localparam logic [SYN_W-1:0] SYN_DIRY  = 4'd8;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_UNKNOWN  = 3'd1,
        ST_NEED_OPD = 3'd2,
        ST_TOO_MANY = 3'd3,
        ST_NOT_CODE = 3'd4
    } t_status;

    typedef struct packed {
        logic              found;
        logic [OP_W-1:0]   base;
        logic [MODE_W-1:0] modes;
    } t_entry;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [SIZE_W-1:0] size;
        logic              branch;
        logic [VAL_W-1:0]  operand;
        logic              emitted;
        t_status           status;
    } t_result;

    function automatic t_entry lookup(input logic [MNEM_W-1:0] name);
        t_entry e;
        e.found = 1'b1;
        e.base  = 8'h00;
        e.modes = M_NONE;
        unique case (name)
            "LDA": begin e.base = 8'hAD; e.modes = M_GEN; end
            "STA": begin e.base = 8'h8D; e.modes = M_GEN & ~M_IMM; end
            "JMP": begin e.base = 8'h4C; e.modes = M_ABS | M_IND | M_INDX; end
            "JSR": begin e.base = 8'h20; e.modes = M_ABS; end
            "RTS": e.base = 8'h60;
            "STZ": begin e.base = 8'h9C; e.modes = M_RMW; end
            "LDX": begin
                e.base  = 8'hAE;
                e.modes = M_IMM | M_ABS | M_ZP | M_ABSY | M_ZPY;
            end
            "STX": begin e.base = 8'h8E; e.modes = M_ABS | M_ZP | M_ABSY | M_ZPY; end
            "LDY": begin e.base = 8'hAC; e.modes = M_IMM | M_RMW; end
            "STY": begin e.base = 8'h8C; e.modes = M_ABS | M_ZP | M_ZPX; end
            "AND": begin e.base = 8'h2D; e.modes = M_GEN; end
            "BIT": begin e.base = 8'h2C; e.modes = M_RMW | M_IMM; end
            "CMP": begin e.base = 8'hCD; e.modes = M_GEN; end
            "CPX": begin e.base = 8'hEC; e.modes = M_IMM | M_ABS | M_ZP; end
            "CPY": begin e.base = 8'hCC; e.modes = M_IMM | M_ABS | M_ZP; end
            "ADC": begin e.base = 8'h6D; e.modes = M_GEN; end
            "SBC": begin e.base = 8'hED; e.modes = M_GEN; end
            "ORA": begin e.base = 8'h0D; e.modes = M_GEN; end
            "EOR": begin e.base = 8'h4D; e.modes = M_GEN; end
            "INC": begin e.base = 8'hEE; e.modes = M_RMW; end
            "DEC": begin e.base = 8'hCE; e.modes = M_RMW; end
            "INA": e.base = 8'h1A;
            "DEA": e.base = 8'h3A;
            "INX": e.base = 8'hE8;
            "DEX": e.base = 8'hCA;
            "INY": e.base = 8'hC8;
            "DEY": e.base = 8'h88;
            "ASL": begin e.base = 8'h0E; e.modes = M_RMW | M_ACC; end
            "ROL": begin e.base = 8'h2E; e.modes = M_RMW | M_ACC; end
            "LSR": begin e.base = 8'h4E; e.modes = M_RMW | M_ACC; end
            "ROR": begin e.base = 8'h6E; e.modes = M_RMW | M_ACC; end
            "TAX": e.base = 8'hAA;
            "TXA": e.base = 8'h8A;
            "TAY": e.base = 8'hA8;
            "TYA": e.base = 8'h98;
            "TSX": e.base = 8'hBA;
            "TXS": e.base = 8'h9A;
            "CLV": e.base = 8'hB8;
            "CLD": e.base = 8'hD8;
            "SED": e.base = 8'hF8;
            "CLI": e.base = 8'h58;
            "SEI": e.base = 8'h78;
            "CLC": e.base = 8'h18;
            "SEC": e.base = 8'h38;
            "BPL": begin e.base = 8'h10; e.modes = M_BR; end
            "BMI": begin e.base = 8'h30; e.modes = M_BR; end
            "BVC": begin e.base = 8'h50; e.modes = M_BR; end
            "BVS": begin e.base = 8'h70; e.modes = M_BR; end
            "BCC": begin e.base = 8'h90; e.modes = M_BR; end
            "BCS": begin e.base = 8'hB0; e.modes = M_BR; end
            "BNE": begin e.base = 8'hD0; e.modes = M_BR; end
            "BEQ": begin e.base = 8'hF0; e.modes = M_BR; end
            "BRA": begin e.base = 8'h80; e.modes = M_BR; end
            "BRK": begin e.base = 8'h00; e.modes = M_IMM; end
            "RTI": e.base = 8'h40;
            "PHP": e.base = 8'h08;
            "PLP": e.base = 8'h28;
            "PHA": e.base = 8'h48;
            "PLA": e.base = 8'h68;
            "PHX": e.base = 8'hDA;
            "PLX": e.base = 8'hFA;
            "PHY": e.base = 8'h5A;
            "PLY": e.base = 8'h7A;
            "NOP": e.base = 8'hEA;
            "TSB": begin e.base = 8'h0C; e.modes = M_ZP | M_ABS; end
            "TRB": begin e.base = 8'h1C; e.modes = M_ZP | M_ABS; end
            default: e.found = 1'b0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cenc_lookup.sv =====
`default_nettype none

module cenc_lookup (
    input  wire logic [cenc_pkg::MNEM_W-1:0] i_mnemonic,
    output cenc_pkg::t_entry                 o_entry
);

    assign o_entry = cenc_pkg::lookup(i_mnemonic);

endmodule

`default_nettype wire

// ===== sv/cenc_encode.sv =====
`default_nettype none

module cenc_encode (
    input  wire cenc_pkg::t_entry            i_entry,
    input  wire logic [cenc_pkg::SYN_W-1:0]  i_operand_syntax,
    input  wire logic [cenc_pkg::VAL_W-1:0]  i_operand_value,
    input  wire logic                        i_value_undefined,
    input  wire logic                        i_value_relocatable,
    input  wire logic                        i_value_low_byte,
    input  wire logic                        i_in_code_segment,
    output cenc_pkg::t_result                o_result
);

    typedef enum logic [3:0] {
        MD_NONE, MD_IMM, MD_ABS, MD_ZP, MD_ABSX, MD_ZPX, MD_ABSY,
        MD_ZPY, MD_INDX, MD_INDY, MD_ACC, MD_IND, MD_BR
    } t_mode;

    t_mode                          mode;
    cenc_pkg::t_status              opd_status;
    logic                           shortp;
    logic [cenc_pkg::OP_W-1:0]      b;
    logic [cenc_pkg::MODE_W-1:0]    m;
    logic [cenc_pkg::OP_W-1:0]      op;
    logic [cenc_pkg::SIZE_W-1:0]    size;
    logic                           br;
    logic [cenc_pkg::VAL_W-1:0]     opnd;

    assign b = i_entry.base;
    assign m = i_entry.modes;
    assign shortp = ((i_operand_value[15:8] == 8'h00) && !i_value_undefined
                    && !i_value_relocatable) || i_value_low_byte;

    always_comb begin
        mode       = MD_NONE;
        opd_status = cenc_pkg::ST_OK;
        opnd       = i_operand_value;
        if (m != cenc_pkg::M_NONE) begin
            priority if (i_operand_syntax == cenc_pkg::SYN_NONE) begin
                if ((m & cenc_pkg::M_ACC) != cenc_pkg::M_NONE) mode = MD_ACC;
                else opd_status = cenc_pkg::ST_NEED_OPD;
            end else if (i_operand_syntax == cenc_pkg::SYN_ACC) begin
                mode = MD_ACC;
            end else if (i_operand_syntax == cenc_pkg::SYN_IMM) begin
                mode = MD_IMM;
                opnd = {8'h00, i_operand_value[7:0]};
            end else if (i_operand_syntax == cenc_pkg::SYN_IND) begin
                mode = MD_IND;
            end else if (i_operand_syntax == cenc_pkg::SYN_INDX) begin
                mode = MD_INDX;
            end else if (i_operand_syntax == cenc_pkg::SYN_INDY) begin
                mode = MD_INDY;
            end else if (i_operand_syntax == cenc_pkg::SYN_DIR) begin
                if ((m & cenc_pkg::M_BR) != cenc_pkg::M_NONE) mode = MD_BR;
                else if ((m & cenc_pkg::M_ZP) == cenc_pkg::M_NONE) mode = MD_ABS;
                else mode = shortp ? MD_ZP : MD_ABS;
            end else if (i_operand_syntax == cenc_pkg::SYN_DIRX) begin
                mode = (shortp && ((m & cenc_pkg::M_ZPX) != cenc_pkg::M_NONE))
                       ? MD_ZPX : MD_ABSX;
            end else if (i_operand_syntax == cenc_pkg::SYN_DIRY) begin
                mode = (shortp && ((m & cenc_pkg::M_ZPY) != cenc_pkg::M_NONE))
                       ? MD_ZPY : MD_ABSY;
            end else begin
                opd_status = cenc_pkg::ST_TOO_MANY;
            end
        end
    end

    always_comb begin
        op   = b;
        size = 2'd0;
        br   = 1'b0;
        unique case (mode)
            MD_IMM: begin
                size = 2'd1;
                priority if (b == 8'h00) op = 8'h00;
                else if (b == 8'h2C) op = 8'h89;
                else if (b[0]) op = b ^ 8'h04;
                else op = (b ^ 8'h04) & 8'hF7;
            end
            MD_ABS: size = 2'd2;
            MD_BR: begin
                size = 2'd1;
                br   = 1'b1;
            end
            MD_ZP: begin
                size = 2'd1;
                op   = (b == 8'h9C) ? 8'h64 : (b ^ 8'h08);
            end
            MD_ABSX: begin
                size = 2'd2;
                op   = (b == 8'h9C) ? 8'h9E : (b ^ 8'h10);
            end
            MD_ZPX: begin
                size = 2'd1;
                op   = (b == 8'h9C) ? 8'h74 : (b ^ 8'h18);
            end
            MD_ABSY: begin
                size = 2'd2;
                op   = (b == 8'hAE) ? 8'hBE : (b ^ 8'h14);
            end
            MD_ZPY: begin
                size = 2'd1;
                op   = b ^ 8'h18;
            end
            MD_INDX: begin
                if (b == 8'h4C) begin
                    op   = 8'h7C;
                    size = 2'd2;
                end else begin
                    op   = b ^ 8'h0C;
                    size = 2'd1;
                end
            end
            MD_INDY: begin
                size = 2'd1;
                op   = b ^ 8'h1C;
            end
            MD_ACC: op = b ^ 8'h04;
            MD_IND: begin
                if (b[3:0] == 4'hD) begin
                    op   = b ^ 8'h1F;
                    size = 2'd1;
                end else begin
                    op   = b ^ 8'h20;
                    size = 2'd2;
                end
            end
            MD_NONE: op = b;
            default: op = b;
        endcase
    end

    always_comb begin
        o_result = '0;
        priority if (!i_entry.found) begin
            o_result.status = cenc_pkg::ST_UNKNOWN;
        end else if (!i_in_code_segment) begin
            o_result.status = (opd_status != cenc_pkg::ST_OK)
                              ? opd_status : cenc_pkg::ST_NOT_CODE;
        end else begin
            o_result.opcode  = op;
            o_result.size    = size;
            o_result.branch  = br;
            o_result.operand = (size != 2'd0) ? opnd : '0;
            o_result.emitted = 1'b1;
            o_result.status  = opd_status;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cmos6502_instruction_encoder.sv =====
// 65SC02 instruction encoder.
// Input channel: drive the mnemonic, syntax class, operand value and flags
// with start high; the word is taken at any rising edge where start is high
// and busy is low. busy stays low, so a word may be taken every cycle.
// Output channel: o_done is high for exactly one cycle with the encoded
// opcode, operand size, branch mark, operand value, emitted flag and status.
// The receiver cannot stall; each result is shown once and must be taken.
// Path: the input register, then the table lookup and encoding feed the
// result register that drives o_done. Throughput: 1 word/cycle.
// Reset: synchronous, active low; clears the valid flags so no result is
// shown until a new word is accepted. Result fields are not reset.
`default_nettype none

module cmos6502_instruction_encoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [cenc_pkg::MNEM_W-1:0] i_mnemonic,
    input  wire logic [cenc_pkg::SYN_W-1:0]  i_operand_syntax,
    input  wire logic [cenc_pkg::VAL_W-1:0]  i_operand_value,
    input  wire logic                        i_value_undefined,
    input  wire logic                        i_value_relocatable,
    input  wire logic                        i_value_low_byte,
    input  wire logic                        i_in_code_segment,
    output logic                             o_done,
    output logic [cenc_pkg::OP_W-1:0]        o_opcode_byte,
    output logic [cenc_pkg::SIZE_W-1:0]      o_operand_size,
    output logic                             o_operand_is_branch,
    output logic [cenc_pkg::VAL_W-1:0]       o_operand_out,
    output logic                             o_emitted,
    output logic [cenc_pkg::STAT_W-1:0]      o_status
);

    logic                        r_in_valid;
    logic [cenc_pkg::MNEM_W-1:0] r_mnemonic;
    logic [cenc_pkg::SYN_W-1:0]  r_syntax;
    logic [cenc_pkg::VAL_W-1:0]  r_value;
    logic                        r_undef;
    logic                        r_reloc;
    logic                        r_low;
    logic                        r_code;
    logic                        r_done;
    cenc_pkg::t_result           r_result;
    cenc_pkg::t_entry            entry;
    cenc_pkg::t_result           n_result;
    logic                        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= accept;
            r_done     <= r_in_valid;
        end
        if (accept) begin
            r_mnemonic <= i_mnemonic;
            r_syntax   <= i_operand_syntax;
            r_value    <= i_operand_value;
            r_undef    <= i_value_undefined;
            r_reloc    <= i_value_relocatable;
            r_low      <= i_value_low_byte;
            r_code     <= i_in_code_segment;
        end
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    cenc_lookup u_lookup (
        .i_mnemonic (r_mnemonic),
        .o_entry    (entry)
    );

    cenc_encode u_encode (
        .i_entry             (entry),
        .i_operand_syntax    (r_syntax),
        .i_operand_value     (r_value),
        .i_value_undefined   (r_undef),
        .i_value_relocatable (r_reloc),
        .i_value_low_byte    (r_low),
        .i_in_code_segment   (r_code),
        .o_result            (n_result)
    );

    assign o_done              = r_done;
    assign o_opcode_byte       = r_result.opcode;
    assign o_operand_size      = r_result.size;
    assign o_operand_is_branch = r_result.branch;
    assign o_operand_out       = r_result.operand;
    assign o_emitted           = r_result.emitted;
    assign o_status            = r_result.status;

endmodule

`default_nettype wire

// ===== sv/cenc_checker.sv =====
`default_nettype none

module cenc_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic                            o_done,
    input  wire logic [cenc_pkg::OP_W-1:0]       o_opcode_byte,
    input  wire logic [cenc_pkg::SIZE_W-1:0]     o_operand_size,
    input  wire logic                            o_operand_is_branch,
    input  wire logic [cenc_pkg::VAL_W-1:0]      o_operand_out,
    input  wire logic                            o_emitted,
    input  wire logic [cenc_pkg::STAT_W-1:0]     o_status
);

    a_word_in_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("accepted word gave no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without accepted word");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_emitted) |-> (o_opcode_byte == '0 && o_operand_size == '0
                                    && o_operand_out == '0 && !o_operand_is_branch))
        else $error("non-emitted result carries data");

    a_branch_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_operand_is_branch) |-> (o_operand_size == 2'd1 && o_emitted))
        else $error("branch operand not one byte");

    a_emit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_emitted) |-> (o_status == cenc_pkg::ST_OK
                                   || o_status == cenc_pkg::ST_NEED_OPD
                                   || o_status == cenc_pkg::ST_TOO_MANY))
        else $error("emitted word with fatal status");

endmodule

bind cmos6502_instruction_encoder cenc_checker u_cenc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_done              (o_done),
    .o_opcode_byte       (o_opcode_byte),
    .o_operand_size      (o_operand_size),
    .o_operand_is_branch (o_operand_is_branch),
    .o_operand_out       (o_operand_out),
    .o_emitted           (o_emitted),
    .o_status            (o_status)
);

`default_nettype wire
